@@ hw/rtl/spq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEF = 16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] prio;
        logic        [15:0] tag;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] out_prio;
        logic        [15:0] out_tag;
        logic               popped;
        logic        [1:0]  status;
        logic        [4:0]  occupancy;
    } t_out_beat;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

endpackage

@@ hw/rtl/spq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: capture a beat, run one queue operation, hold the result.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output spq_pkg::t_dp_cmd o_cmd
);

    spq_pkg::t_state r_state;
    spq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            spq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = spq_pkg::S_EXEC;
                end
            end
            spq_pkg::S_EXEC: begin
                n_state = spq_pkg::S_RESP;
            end
            spq_pkg::S_RESP: begin
                if (i_out_ready) begin
                    n_state = spq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            spq_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            spq_pkg::S_EXEC: begin
                o_cmd.execute = 1'b1;
            end
            spq_pkg::S_RESP: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hw/rtl/spq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath
// Row of compare-and-shift cells holding entries in ascending priority order.
// ----------------------------------------------------------------------------
module spq_datapath #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spq_pkg::t_dp_cmd   i_cmd,
    input  spq_pkg::t_in_beat  i_in_data,
    output spq_pkg::t_out_beat o_out_data
);

    localparam int CW = $clog2(DEPTH + 1);

    spq_pkg::t_in_beat  r_op;
    spq_pkg::t_out_beat r_out;
    spq_pkg::t_out_beat n_out;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;

    logic signed [15:0] r_cell_prio [DEPTH];
    logic        [15:0] r_cell_tag  [DEPTH];
    logic [DEPTH-1:0]   w_le;
    logic               w_full;
    logic               w_empty;
    logic               w_do_ins;
    logic               w_do_pop;

    assign w_full   = (r_count == CW'(DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_do_ins = i_cmd.execute && (r_op.cmd == spq_pkg::CMD_INSERT) && !w_full;
    assign w_do_pop = i_cmd.execute && (r_op.cmd == spq_pkg::CMD_POP) && !w_empty;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_le[i] = (CW'(i) < r_count) && (r_cell_prio[i] <= r_op.prio);
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [15:0] n_prio;
        logic        [15:0] n_tag;

        always_comb begin
            n_prio = r_cell_prio[g];
            n_tag  = r_cell_tag[g];
            if (w_do_ins && !w_le[g]) begin
                if (g == 0) begin
                    n_prio = r_op.prio;
                    n_tag  = r_op.tag;
                end else if (w_le[(g == 0) ? 0 : g - 1]) begin
                    n_prio = r_op.prio;
                    n_tag  = r_op.tag;
                end else begin
                    n_prio = r_cell_prio[(g == 0) ? 0 : g - 1];
                    n_tag  = r_cell_tag[(g == 0) ? 0 : g - 1];
                end
            end else if (w_do_pop && (g < DEPTH - 1)) begin
                n_prio = r_cell_prio[(g < DEPTH - 1) ? g + 1 : g];
                n_tag  = r_cell_tag[(g < DEPTH - 1) ? g + 1 : g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_cell_prio[g] <= n_prio;
            r_cell_tag[g]  <= n_tag;
        end
    end

    always_comb begin
        n_count        = r_count;
        n_out.out_prio = '0;
        n_out.out_tag  = '0;
        n_out.popped   = 1'b0;
        n_out.status   = spq_pkg::ST_OK;
        if (r_op.cmd == spq_pkg::CMD_INSERT) begin
            if (w_full) begin
                n_out.status = spq_pkg::ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_out.status = spq_pkg::ST_EMPTY;
            end else begin
                n_out.out_prio = r_cell_prio[0];
                n_out.out_tag  = r_cell_tag[0];
                n_out.popped   = 1'b1;
                n_count        = r_count - 1'b1;
            end
        end
        n_out.occupancy = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.execute) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_in_data;
        end
        if (i_cmd.execute) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

@@ hw/rtl/sorted_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue of (priority, tag) entries, smallest priority first.
// ----------------------------------------------------------------------------
// channel | direction | handshake                | payload
// in      | input     | i_in_valid / o_in_ready  | i_in_data  (cmd, prio, tag)
// out     | output    | o_out_valid / i_out_ready| o_out_data (prio, tag, flags)
//
// Each beat passes through capture, one insert or pop across the cell row,
// and a result state; the result holds until taken. The next beat is accepted
// in the cycle after the result leaves. Reset empties the queue by clearing its count.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  spq_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output spq_pkg::t_out_beat o_out_data
);

    spq_pkg::t_dp_cmd w_cmd;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input accepted while a result is pending");

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second beat accepted during an operation");

    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.popped) |-> (o_out_data.status == spq_pkg::ST_OK))
        else $error("popped entry with error status");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.popped)
            |-> (o_out_data.out_prio == '0 && o_out_data.out_tag == '0))
        else $error("nonzero payload without a popped entry");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_priority_queue. A queue model predicts every
// result beat from the accepted command beats. Directed tests cover the empty
// pop, full-range priorities with ties, and the full reject. Random traffic
// with shifting insert/pop mixes and idle gaps on both channels follows. An
// output stall fills the block, and pauses wait for the pipe to drain.
// ----------------------------------------------------------------------------
module testbench;

    localparam int QUEUE_DEPTH = spq_pkg::DEPTH_DEF;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    spq_pkg::t_in_beat  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    spq_pkg::t_out_beat o_out_data;

    sorted_priority_queue #(.DEPTH(QUEUE_DEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // model of the held entries, front at index 0
    logic signed [15:0] held_prio [QUEUE_DEPTH];
    logic        [15:0] held_tag  [QUEUE_DEPTH];
    int                 held_count = 0;

    spq_pkg::t_out_beat pending_results [$];
    spq_pkg::t_out_beat want;

    int mismatch_count = 0;
    int beats_in       = 0;
    int beats_checked  = 0;
    int pops_hit       = 0;
    int full_rejects   = 0;
    int empty_pops     = 0;

    int tx_max_gap  = 0;
    int rx_max_gap  = 0;
    int rx_hold_len = 0;

    function automatic spq_pkg::t_out_beat apply_queue_op(input spq_pkg::t_in_beat beat);
        spq_pkg::t_out_beat res;
        int                 pos;
        int                 i;
        res = '0;
        if (beat.cmd == spq_pkg::CMD_INSERT) begin
            if (held_count >= QUEUE_DEPTH) begin
                res.status = spq_pkg::ST_FULL;
            end else begin
                pos = 0;
                while (pos < held_count && $signed(held_prio[pos]) <= $signed(beat.prio))
                    pos++;
                for (i = held_count; i > pos; i--) begin
                    held_prio[i] = held_prio[i-1];
                    held_tag[i]  = held_tag[i-1];
                end
                held_prio[pos] = beat.prio;
                held_tag[pos]  = beat.tag;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                res.status = spq_pkg::ST_EMPTY;
            end else begin
                res.out_prio = held_prio[0];
                res.out_tag  = held_tag[0];
                res.popped   = 1'b1;
                for (i = 1; i < held_count; i++) begin
                    held_prio[i-1] = held_prio[i];
                    held_tag[i-1]  = held_tag[i];
                end
                held_count--;
            end
        end
        res.occupancy = 5'(held_count);
        return res;
    endfunction

    // check output beats first: a result never leaves on its own input edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                beats_checked++;
                if (pending_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: result beat with nothing pending: prio=%0d tag=%h",
                                 $realtime, o_out_data.out_prio, o_out_data.out_tag);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.out_prio  !== want.out_prio  ||
                        o_out_data.out_tag   !== want.out_tag   ||
                        o_out_data.popped    !== want.popped    ||
                        o_out_data.status    !== want.status    ||
                        o_out_data.occupancy !== want.occupancy) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: expected prio=%0d tag=%h popped=%b status=%0d occ=%0d",
                                     $realtime, want.out_prio, want.out_tag, want.popped,
                                     want.status, want.occupancy);
                            $display("%0t: actual   prio=%0d tag=%h popped=%b status=%0d occ=%0d",
                                     $realtime, o_out_data.out_prio, o_out_data.out_tag,
                                     o_out_data.popped, o_out_data.status,
                                     o_out_data.occupancy);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                want = apply_queue_op(i_in_data);
                pending_results.push_back(want);
                beats_in++;
                if (want.popped)
                    pops_hit++;
                if (want.status == spq_pkg::ST_FULL)
                    full_rejects++;
                if (want.status == spq_pkg::ST_EMPTY)
                    empty_pops++;
            end
        end
    end

    // result receiver: random stall per beat, long hold on request
    initial begin
        int gap;
        bit got;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (rx_hold_len > 0) begin
                i_out_ready <= 1'b0;
                repeat (rx_hold_len) @(posedge i_clk);
                rx_hold_len = 0;
            end
            gap = $urandom_range(0, rx_max_gap);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            got = 1'b0;
            while (!got) begin
                @(posedge i_clk);
                got = o_out_valid || rx_hold_len > 0;
            end
        end
    end

    task automatic send_beat(input spq_pkg::t_in_beat beat);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic spq_pkg::t_in_beat make_beat(input logic        cmd,
                                                    input logic [15:0] prio,
                                                    input logic [15:0] tag);
        spq_pkg::t_in_beat beat;
        beat.cmd  = cmd;
        beat.prio = prio;
        beat.tag  = tag;
        return beat;
    endfunction

    task automatic test_empty_pop();
        tx_max_gap = 0;
        rx_max_gap = 0;
        send_beat(make_beat(spq_pkg::CMD_POP, 16'h7FFF, 16'hFFFF));
    endtask

    task automatic test_fill_with_ties();
        logic [15:0] prio_list [QUEUE_DEPTH];
        int          k;
        prio_list = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000,
                      16'h0000, 16'h7FFF, 16'h8000, 16'h0005, 16'hFFFB, 16'h0000,
                      16'h0064, 16'hFF9C, 16'h0001, 16'hFFFF};
        for (k = 0; k < QUEUE_DEPTH; k++)
            send_beat(make_beat(spq_pkg::CMD_INSERT, prio_list[k],
                                k == 0 ? 16'hFFFF : k == 1 ? 16'h0000 : 16'(16'h1000 + k)));
        send_beat(make_beat(spq_pkg::CMD_INSERT, 16'h0000, 16'h5555));
        tx_max_gap = 16;
        rx_max_gap = 16;
        for (k = 0; k < 4; k++)
            send_beat(make_beat(spq_pkg::CMD_POP, 16'(k), 16'hAAAA));
        wait_drained();
    endtask

    task automatic test_output_stall();
        int k;
        tx_max_gap  = 0;
        rx_max_gap  = 0;
        rx_hold_len = 400;
        for (k = 0; k < 8; k++)
            send_beat(make_beat(k[0] ? spq_pkg::CMD_POP : spq_pkg::CMD_INSERT,
                                16'($urandom), 16'($urandom)));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_items);
        int                k;
        int                insert_pct;
        int                small_prio;
        spq_pkg::t_in_beat beat;
        for (k = 0; k < n_items; k++) begin
            if (k % 24 == 0) begin
                insert_pct = 25 * $urandom_range(1, 3);
                case ($urandom_range(0, 3))
                    0: begin tx_max_gap = 0;  rx_max_gap = 0;  end
                    1: begin tx_max_gap = 16; rx_max_gap = 0;  end
                    2: begin tx_max_gap = 0;  rx_max_gap = 16; end
                    default: begin tx_max_gap = 16; rx_max_gap = 16; end
                endcase
            end
            small_prio = $urandom_range(0, 8);
            beat.cmd  = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::CMD_INSERT
                                                              : spq_pkg::CMD_POP;
            beat.prio = $urandom_range(0, 1) ? 16'($urandom) : 16'(small_prio - 4);
            beat.tag  = 16'($urandom);
            send_beat(beat);
            if (k % 150 == 149)
                wait_drained();
        end
    endtask

    initial begin
        int guard;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_pop();
        test_fill_with_ties();
        test_random_traffic(280);
        test_output_stall();
        test_random_traffic(290);

        i_in_valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d expected result beats never arrived", pending_results.size());
            mismatch_count += pending_results.size();
        end

        $display("Run: %0d command beats in, %0d result beats checked, %0d mismatches",
                 beats_in, beats_checked, mismatch_count);
        $display("Run: %0d entries popped, %0d inserts rejected full, %0d pops on empty",
                 pops_hit, full_rejects, empty_pops);
        if (mismatch_count == 0) begin
            $display("sorted_priority_queue verification clean");
        end else begin
            $display("sorted_priority_queue verification failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Timeout with %0d result beats pending", pending_results.size());
        $display("sorted_priority_queue verification failed");
        $finish;
    end

endmodule
